>>> rtl/reserved_id_table_assert.svh
// Assertion macros for the reserved ID table RTL.
// Used by rit_dp.sv; expects i_clk and i_rst_n in the including module.
`ifndef RESERVED_ID_TABLE_ASSERT_SVH
`define RESERVED_ID_TABLE_ASSERT_SVH

`ifndef SYNTHESIS
// Checked only while out of reset
`define RIT_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) \
        else $error("reserved_id_table: assertion failed");
// Checked at every edge, reset included
`define RIT_ASSERT_ALWAYS(lbl, prop) \
    lbl: assert property (@(posedge i_clk) prop) \
        else $error("reserved_id_table: assertion failed");
`else
`define RIT_ASSERT(lbl, prop)
`define RIT_ASSERT_ALWAYS(lbl, prop)
`endif

`endif

>>> rtl/rit_pkg.sv
// Shared types and constants for the reserved ID table.
// No dependencies; imported by rit_seq, rit_dp and reserved_id_table.
package rit_pkg;

    localparam int CAPACITY  = 256;
    localparam int IDX_W     = $clog2(CAPACITY);
    localparam int CNT_W     = $clog2(CAPACITY + 1);
    localparam int ID_W      = 16;
    localparam int OP_W      = 3;
    localparam int ENTRIES_W = 9;
    localparam int UPC_W     = 5;

    typedef logic [UPC_W-1:0] t_upc;

    // Operation codes
    typedef enum logic [OP_W-1:0] {
        OP_RESERVE = 3'd0,
        OP_FREE    = 3'd1,
        OP_CHECK   = 3'd2,
        OP_CLAIM   = 3'd3,
        OP_FLUSH   = 3'd4
    } t_op;

    // Jump conditions of the microcode
    typedef enum logic [3:0] {
        C_NEVER,
        C_ALWAYS,
        C_NO_VALID,
        C_OP_RESERVE,
        C_OP_FREE,
        C_OP_CHECK,
        C_OP_CLAIM,
        C_OP_FLUSH,
        C_SCAN_DONE,
        C_FOUND,
        C_FULL,
        C_OUT_BUSY
    } t_cond;

    // Datapath actions, one bit each
    typedef struct packed {
        logic load;      // capture transaction, clear flags and pointers
        logic read;      // read entry at read pointer
        logic rng;       // range compare on read data, advance read pointer
        logic cmp;       // compact: keep non-matching entry, advance pointers
        logic set_cnt;   // count <= write pointer
        logic clr_cnt;   // count <= 0
        logic append;    // store id at count, count++
        logic set_full;  // flag refusal on full list
        logic emit;      // load result register
    } t_ctrl;

    // One control word
    typedef struct packed {
        t_ctrl act;
        t_cond cond;
        t_upc  target;
    } t_uword;

    // Datapath status to the sequencer
    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            scan_done;
        logic            found;
        logic            full;
        logic            out_busy;
    } t_stat;

endpackage

>>> rtl/rit_seq.sv
// Microcode sequencer: step counter, control-word ROM and jump logic.
// Depends on rit_pkg.
module rit_seq (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_in_valid,
    input  rit_pkg::t_stat i_stat,
    output rit_pkg::t_ctrl o_ctrl,
    output logic           o_in_stall
);
    import rit_pkg::*;

    // Step addresses
    localparam t_upc S_IDLE       = 5'd0;
    localparam t_upc S_DISP_RES   = 5'd1;
    localparam t_upc S_DISP_FREE  = 5'd2;
    localparam t_upc S_DISP_CHK   = 5'd3;
    localparam t_upc S_DISP_CLM   = 5'd4;
    localparam t_upc S_DISP_FLUSH = 5'd5;
    localparam t_upc S_DISP_OTHER = 5'd6;
    localparam t_upc S_SCAN_RD    = 5'd7;
    localparam t_upc S_SCAN_TST   = 5'd8;
    localparam t_upc S_SCAN_END   = 5'd9;
    localparam t_upc S_CLM_TST    = 5'd10;
    localparam t_upc S_APP_CHK    = 5'd11;
    localparam t_upc S_APP        = 5'd12;
    localparam t_upc S_SET_FULL   = 5'd13;
    localparam t_upc S_FREE_RD    = 5'd14;
    localparam t_upc S_FREE_CMP   = 5'd15;
    localparam t_upc S_FREE_END   = 5'd16;
    localparam t_upc S_FLUSH      = 5'd17;
    localparam t_upc S_DONE       = 5'd18;
    localparam t_upc S_RET        = 5'd19;

    localparam t_ctrl A_NONE = '0;

    // Control store
    function automatic t_uword rom(input t_upc addr);
        t_uword w;
        w = '{act: A_NONE, cond: C_NEVER, target: S_IDLE};
        unique case (addr)
            S_IDLE: begin
                w.act.load = 1'b1;
                w.cond     = C_NO_VALID;
                w.target   = S_IDLE;
            end
            S_DISP_RES:   begin w.cond = C_OP_RESERVE; w.target = S_APP_CHK; end
            S_DISP_FREE:  begin w.cond = C_OP_FREE;    w.target = S_FREE_RD; end
            S_DISP_CHK:   begin w.cond = C_OP_CHECK;   w.target = S_SCAN_RD; end
            S_DISP_CLM:   begin w.cond = C_OP_CLAIM;   w.target = S_SCAN_RD; end
            S_DISP_FLUSH: begin w.cond = C_OP_FLUSH;   w.target = S_FLUSH;   end
            S_DISP_OTHER: begin w.cond = C_ALWAYS;     w.target = S_DONE;    end
            S_SCAN_RD: begin
                w.act.read = 1'b1;
                w.cond     = C_SCAN_DONE;
                w.target   = S_SCAN_END;
            end
            S_SCAN_TST: begin
                w.act.rng = 1'b1;
                w.cond    = C_ALWAYS;
                w.target  = S_SCAN_RD;
            end
            S_SCAN_END:   begin w.cond = C_OP_CHECK; w.target = S_DONE;     end
            S_CLM_TST:    begin w.cond = C_FOUND;    w.target = S_DONE;     end
            S_APP_CHK:    begin w.cond = C_FULL;     w.target = S_SET_FULL; end
            S_APP: begin
                w.act.append = 1'b1;
                w.cond       = C_ALWAYS;
                w.target     = S_DONE;
            end
            S_SET_FULL: begin
                w.act.set_full = 1'b1;
                w.cond         = C_ALWAYS;
                w.target       = S_DONE;
            end
            S_FREE_RD: begin
                w.act.read = 1'b1;
                w.cond     = C_SCAN_DONE;
                w.target   = S_FREE_END;
            end
            S_FREE_CMP: begin
                w.act.cmp = 1'b1;
                w.cond    = C_ALWAYS;
                w.target  = S_FREE_RD;
            end
            S_FREE_END: begin
                w.act.set_cnt = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = S_DONE;
            end
            S_FLUSH: begin
                w.act.clr_cnt = 1'b1;
                w.cond        = C_ALWAYS;
                w.target      = S_DONE;
            end
            // wait here until the result register is free
            S_DONE: begin
                w.act.emit = 1'b1;
                w.cond     = C_OUT_BUSY;
                w.target   = S_DONE;
            end
            S_RET:        begin w.cond = C_ALWAYS; w.target = S_IDLE; end
            default:      begin w.cond = C_ALWAYS; w.target = S_IDLE; end
        endcase
        return w;
    endfunction

    t_upc   r_upc;
    t_upc   n_upc;
    t_uword uw;
    logic   take;

    assign uw = rom(r_upc);

    // Condition decode
    always_comb begin
        unique case (uw.cond)
            C_NEVER:      take = 1'b0;
            C_ALWAYS:     take = 1'b1;
            C_NO_VALID:   take = !i_in_valid;
            C_OP_RESERVE: take = (i_stat.op == OP_RESERVE);
            C_OP_FREE:    take = (i_stat.op == OP_FREE);
            C_OP_CHECK:   take = (i_stat.op == OP_CHECK);
            C_OP_CLAIM:   take = (i_stat.op == OP_CLAIM);
            C_OP_FLUSH:   take = (i_stat.op == OP_FLUSH);
            C_SCAN_DONE:  take = i_stat.scan_done;
            C_FOUND:      take = i_stat.found;
            C_FULL:       take = i_stat.full;
            C_OUT_BUSY:   take = i_stat.out_busy;
            default:      take = 1'b1;
        endcase
    end

    // Next step
    always_comb begin
        n_upc = take ? uw.target : t_upc'(r_upc + 1'b1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_upc <= S_IDLE;
        end else begin
            r_upc <= n_upc;
        end
    end

    // Action outputs, with handshake gating
    always_comb begin
        o_ctrl      = uw.act;
        o_ctrl.load = uw.act.load && i_in_valid;
        o_ctrl.emit = uw.act.emit && !i_stat.out_busy;
        o_in_stall  = (r_upc != S_IDLE);
    end

endmodule

>>> rtl/rit_dp.sv
// Datapath: ID memory, pointers, count, flags and result register.
// Depends on rit_pkg and reserved_id_table_assert.svh.
`include "reserved_id_table_assert.svh"

module rit_dp (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  rit_pkg::t_ctrl           i_ctrl,
    input  logic [rit_pkg::OP_W-1:0] i_op,
    input  logic [rit_pkg::ID_W-1:0] i_id,
    input  logic [rit_pkg::ID_W-1:0] i_span,
    input  logic                     i_out_stall,
    output rit_pkg::t_stat           o_stat,
    output logic                     o_out_valid,
    output logic                     o_found,
    output logic                     o_accepted,
    output logic                     o_full_res,
    output logic [rit_pkg::ENTRIES_W-1:0] o_entries
);
    import rit_pkg::*;

    logic [ID_W-1:0] mem [CAPACITY];

    logic [OP_W-1:0] r_op;
    logic [ID_W-1:0] r_id;
    logic [ID_W:0]   r_hi;
    logic [ID_W-1:0] r_rdata;
    logic [CNT_W-1:0] r_rd;
    logic [CNT_W-1:0] r_wr;
    logic [CNT_W-1:0] r_count;
    logic            r_found;
    logic            r_acc;
    logic            r_full;
    logic            r_out_valid;

    logic            keep;
    logic            in_range;
    logic            we;
    logic [IDX_W-1:0] waddr;
    logic [ID_W-1:0] wdata;

    // Compare logic on the read data
    assign keep     = (r_rdata != r_id);
    assign in_range = (r_rdata >= r_id) && ({1'b0, r_rdata} <= r_hi);

    // Single write port: compaction or append
    assign we    = (i_ctrl.cmp && keep) || i_ctrl.append;
    assign waddr = i_ctrl.append ? r_count[IDX_W-1:0] : r_wr[IDX_W-1:0];
    assign wdata = i_ctrl.append ? r_id : r_rdata;

    // ID memory, registered read
    always_ff @(posedge i_clk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (i_ctrl.read) begin
            r_rdata <= mem[r_rd[IDX_W-1:0]];
        end
    end

    // Transaction capture, pointers and flags
    always_ff @(posedge i_clk) begin
        if (i_ctrl.load) begin
            r_op    <= i_op;
            r_id    <= i_id;
            r_hi    <= {1'b0, i_id} + {1'b0, i_span};
            r_rd    <= '0;
            r_wr    <= '0;
            r_found <= 1'b0;
            r_acc   <= 1'b0;
            r_full  <= 1'b0;
        end else begin
            if (i_ctrl.rng || i_ctrl.cmp) begin
                r_rd <= r_rd + 1'b1;
            end
            if (i_ctrl.cmp && keep) begin
                r_wr <= r_wr + 1'b1;
            end
            if (i_ctrl.rng && in_range) begin
                r_found <= 1'b1;
            end
            if (i_ctrl.append) begin
                r_acc <= 1'b1;
            end
            if (i_ctrl.set_full) begin
                r_full <= 1'b1;
            end
        end
    end

    // Entry count
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (i_ctrl.clr_cnt) begin
            r_count <= '0;
        end else if (i_ctrl.set_cnt) begin
            r_count <= r_wr;
        end else if (i_ctrl.append) begin
            r_count <= r_count + 1'b1;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_ctrl.emit) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctrl.emit) begin
            o_found    <= r_found;
            o_accepted <= r_acc;
            o_full_res <= r_full;
            o_entries  <= ENTRIES_W'(r_count);
        end
    end

    assign o_out_valid      = r_out_valid;
    assign o_stat.op        = r_op;
    assign o_stat.scan_done = (r_rd >= r_count);
    assign o_stat.found     = r_found;
    assign o_stat.full      = (r_count >= CNT_W'(CAPACITY));
    assign o_stat.out_busy  = r_out_valid && i_out_stall;

    // Checks
    `RIT_ASSERT(a_count_max, r_count <= CNT_W'(CAPACITY))
    `RIT_ASSERT(a_emit_free, i_ctrl.emit |-> !(r_out_valid && i_out_stall))
    `RIT_ASSERT(a_load_clear, i_ctrl.load |=> (!r_found && !r_acc && !r_full))
    `RIT_ASSERT(a_compact_order, (i_ctrl.cmp || i_ctrl.set_cnt) |-> (r_wr <= r_rd))

endmodule

>>> rtl/reserved_id_table.sv
// Top level of the reserved ID table: sequencer plus datapath.
// Depends on rit_pkg, rit_seq and rit_dp.
//
// Usage:
//  - Input channel (i_in_valid / o_in_stall) carries one operation per
//    transaction: op, id and span. Output channel (o_out_valid /
//    i_out_stall) returns exactly one result per operation.
//  - One operation is in flight at a time; o_in_stall is low only while
//    the sequencer waits at its idle step.
//  - Free, check and claim scan all N stored entries before the result,
//    reading, then testing, each entry through the single read port;
//    reserve, flush and unknown codes do not scan. The next transaction
//    is taken after the result appears, once the sequencer has passed its
//    return step back to idle.
//  - Result register: a finished result waits there while the next
//    operation is accepted and processed; the sequencer holds at its
//    final step only when that register is still occupied and stalled.
//  - Reset (synchronous, active low) empties the list and clears the
//    result valid; memory contents are not cleared, only entries below
//    the count are ever used.
module reserved_id_table (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [rit_pkg::OP_W-1:0]      i_op,
    input  logic [rit_pkg::ID_W-1:0]      i_id,
    input  logic [rit_pkg::ID_W-1:0]      i_span,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic                          o_found,
    output logic                          o_accepted,
    output logic                          o_full_res,
    output logic [rit_pkg::ENTRIES_W-1:0] o_entries
);
    import rit_pkg::*;

    t_ctrl ctrl;
    t_stat stat;

    // Microcode sequencer
    rit_seq u_seq (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (stat),
        .o_ctrl     (ctrl),
        .o_in_stall (o_in_stall)
    );

    // Datapath with ID memory
    rit_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctrl      (ctrl),
        .i_op        (i_op),
        .i_id        (i_id),
        .i_span      (i_span),
        .i_out_stall (i_out_stall),
        .o_stat      (stat),
        .o_out_valid (o_out_valid),
        .o_found     (o_found),
        .o_accepted  (o_accepted),
        .o_full_res  (o_full_res),
        .o_entries   (o_entries)
    );

endmodule

>>> verif/rit_tb_pkg.sv
`timescale 1ns / 1ps
// Scoreboard for the reserved ID table testbench: keeps its own copy of the ID list.
// From it, predicts one outcome per operation and checks the results against that.
// Depends on rit_pkg for widths, capacity and operation codes.
package rit_tb_pkg;

    import rit_pkg::*;

    // Fields of one result transaction
    typedef struct packed {
        logic                 found;
        logic                 accepted;
        logic                 full_res;
        logic [ENTRIES_W-1:0] entries;
    } t_outcome;

    class id_table_tracker;

        logic [ID_W-1:0] held_ids [CAPACITY];
        int unsigned     occupancy;
        t_outcome        outcome_q [$];
        int              mismatches;

        function new();
            occupancy  = 0;
            mismatches = 0;
        endfunction

        // Any stored ID in lo..lo+span; the upper bound is formed at 32 bits
        function bit range_taken(logic [ID_W-1:0] lo, logic [ID_W-1:0] span);
            int unsigned hi;
            bit          hit;
            hi  = 32'(lo) + 32'(span);
            hit = 1'b0;
            for (int k = 0; k < occupancy; k++) begin
                if (32'(held_ids[k]) >= 32'(lo) && 32'(held_ids[k]) <= hi)
                    hit = 1'b1;
            end
            return hit;
        endfunction

        // Append at the tail; refused when the list is full
        function bit take_slot(logic [ID_W-1:0] id);
            if (occupancy >= CAPACITY)
                return 1'b0;
            held_ids[occupancy] = id;
            occupancy++;
            return 1'b1;
        endfunction

        // Predict the outcome of an accepted operation and queue it
        function void note_op(logic [OP_W-1:0] op, logic [ID_W-1:0] id,
                              logic [ID_W-1:0] span);
            t_outcome    want;
            int unsigned wr;
            want = '0;
            case (op)
                OP_RESERVE: begin
                    if (take_slot(id))
                        want.accepted = 1'b1;
                    else
                        want.full_res = 1'b1;
                end
                OP_FREE: begin
                    // compact in place, keeping order, every copy removed
                    wr = 0;
                    for (int rd = 0; rd < occupancy; rd++) begin
                        if (held_ids[rd] != id) begin
                            held_ids[wr] = held_ids[rd];
                            wr++;
                        end
                    end
                    occupancy = wr;
                end
                OP_CHECK: want.found = range_taken(id, span);
                OP_CLAIM: begin
                    if (range_taken(id, span))
                        want.found = 1'b1;
                    else if (take_slot(id))
                        want.accepted = 1'b1;
                    else
                        want.full_res = 1'b1;
                end
                OP_FLUSH: occupancy = 0;
                default: ;
            endcase
            want.entries = ENTRIES_W'(occupancy);
            outcome_q.push_back(want);
        endfunction

        // Compare one result transaction with the oldest prediction
        function void check_outcome(logic found, logic accepted, logic full_res,
                                    logic [ENTRIES_W-1:0] entries);
            t_outcome want;
            if (outcome_q.size() == 0) begin
                mismatches++;
                $error("result with no operation outstanding");
                return;
            end
            want = outcome_q.pop_front();
            if (found !== want.found) begin
                mismatches++;
                $error("found mismatch: expected %0d, got %0d", want.found, found);
            end
            if (accepted !== want.accepted) begin
                mismatches++;
                $error("accepted mismatch: expected %0d, got %0d", want.accepted, accepted);
            end
            if (full_res !== want.full_res) begin
                mismatches++;
                $error("full_res mismatch: expected %0d, got %0d", want.full_res, full_res);
            end
            if (entries !== want.entries) begin
                mismatches++;
                $error("entries mismatch: expected %0d, got %0d", want.entries, entries);
            end
        endfunction

        function int outstanding();
            return outcome_q.size();
        endfunction

    endclass

endpackage

>>> verif/testbench.sv
`timescale 1ns / 1ps
// Top-level testbench for reserved_id_table: directed cases, then random episodes.
// Episodes work on small ID pools, up to two of them fill the list to capacity, with random idling.
// Depends on rit_pkg, rit_tb_pkg and the reserved_id_table RTL.
module testbench;

    import rit_pkg::*;
    import rit_tb_pkg::*;

    localparam int RANDOM_OPS     = 1100;
    localparam int RX_HOLD_CYCLES = 3000;
    localparam int CYCLE_LIMIT    = 5_000_000;
    localparam int SETTLE_CYCLES  = 600;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [OP_W-1:0]      i_op;
    logic [ID_W-1:0]      i_id;
    logic [ID_W-1:0]      i_span;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic                 o_found;
    logic                 o_accepted;
    logic                 o_full_res;
    logic [ENTRIES_W-1:0] o_entries;

    id_table_tracker tracker;
    int              ops_issued = 0;
    int              cycles     = 0;
    bit              hold_rx    = 1'b0;

    reserved_id_table u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_op        (i_op),
        .i_id        (i_id),
        .i_span      (i_span),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_found     (o_found),
        .o_accepted  (o_accepted),
        .o_full_res  (o_full_res),
        .o_entries   (o_entries)
    );

    // 20 ns clock
    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    // Run limit
    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        if (r < 88)
            return $urandom_range(1, 4);
        if (r < 97)
            return $urandom_range(5, 15);
        return $urandom_range(30, 80);
    endfunction

    // Pool base: near zero, straddling the top of the ID space, or anywhere
    function automatic logic [ID_W-1:0] pick_base();
        int r;
        r = $urandom_range(0, 9);
        if (r < 2)
            return '0;
        if (r < 4)
            return 16'hFFF8;
        return ID_W'($urandom);
    endfunction

    function automatic logic [ID_W-1:0] pick_id(logic [ID_W-1:0] base);
        if ($urandom_range(0, 99) < 85)
            return base + ID_W'($urandom_range(0, 15));
        return ID_W'($urandom);
    endfunction

    function automatic logic [ID_W-1:0] pick_span();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return ID_W'($urandom);
            default: return ID_W'($urandom_range(0, 7));
        endcase
    endfunction

    // Receiver: random stall bursts, one long hold-off on request
    initial begin : rx_side
        int n;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_rx) begin
                i_out_stall <= 1'b1;
                repeat (RX_HOLD_CYCLES - 1) @(negedge i_clk);
                hold_rx = 1'b0;
            end else if ($urandom_range(0, 3) == 0) begin
                n = idle_len();
                i_out_stall <= 1'b1;
                repeat (n) @(negedge i_clk);
            end else begin
                i_out_stall <= 1'b0;
                repeat ($urandom_range(0, 30)) @(negedge i_clk);
            end
        end
    end

    // Result monitor
    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall === 1'b0)
            tracker.check_outcome(o_found, o_accepted, o_full_res, o_entries);
    end

    // Offer one transaction, wait for it to be taken, then maybe idle
    task automatic send_op(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id,
                           input logic [ID_W-1:0] span);
        int gap;
        @(negedge i_clk);
        i_in_valid <= 1'b1;
        i_op       <= op;
        i_id       <= id;
        i_span     <= span;
        do @(posedge i_clk); while (o_in_stall !== 1'b0);
        tracker.note_op(op, id, span);
        ops_issued++;
        gap = idle_len();
        if (gap > 0) begin
            @(negedge i_clk);
            i_in_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
    endtask

    // One random operation on a small pool of IDs, unknown codes mixed in
    task automatic pool_op(input logic [ID_W-1:0] base);
        logic [OP_W-1:0] op;
        int              r;
        r = $urandom_range(0, 99);
        if (r < 30)
            op = OP_RESERVE;
        else if (r < 45)
            op = OP_FREE;
        else if (r < 65)
            op = OP_CHECK;
        else if (r < 88)
            op = OP_CLAIM;
        else if (r < 92)
            op = OP_FLUSH;
        else
            op = OP_W'($urandom_range(5, 7));
        send_op(op, pick_id(base), pick_span());
    endtask

    // Stop offering until every result has come back
    task automatic drain();
        @(negedge i_clk);
        i_in_valid <= 1'b0;
        while (tracker.outstanding() != 0) @(posedge i_clk);
    endtask

    // Fill the list to capacity with duplicate runs, then work on the full list
    task automatic fill_episode();
        logic [ID_W-1:0] base;
        logic [ID_W-1:0] id;
        base = pick_base();
        send_op(OP_FLUSH, ID_W'($urandom), ID_W'($urandom));
        while (tracker.occupancy < CAPACITY) begin
            id = pick_id(base);
            repeat ($urandom_range(1, 3)) begin
                if (tracker.occupancy < CAPACITY)
                    send_op(OP_RESERVE, id, ID_W'($urandom));
            end
        end
        // refused reserve, claim of an open range, claim of a busy range
        send_op(OP_RESERVE, pick_id(base), ID_W'($urandom));
        send_op(OP_CLAIM, base + 16'd4096, '0);
        send_op(OP_CLAIM, base, 16'd15);
        send_op(OP_CHECK, base + 16'd4096, pick_span());
        repeat ($urandom_range(6, 12)) pool_op(base);
        send_op(OP_FLUSH, ID_W'($urandom), ID_W'($urandom));
    endtask

    initial begin : stimulus
        int              start;
        int              fills;
        bit              hold_done;
        logic [ID_W-1:0] base;

        tracker    = new();
        fills      = 0;
        hold_done  = 1'b0;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_op       = '0;
        i_id       = '0;
        i_span     = '0;
        repeat (8) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty list, duplicates, range without wrap, unknown codes
        send_op(OP_CHECK, 16'h0000, 16'hFFFF);
        send_op(OP_RESERVE, 16'h0000, 16'h0000);
        send_op(OP_RESERVE, 16'h1234, 16'hFFFF);
        send_op(OP_RESERVE, 16'h1234, 16'h0000);
        send_op(OP_RESERVE, 16'h1234, 16'h5555);
        send_op(OP_RESERVE, 16'h0005, 16'hAAAA);
        send_op(OP_CHECK, 16'hFFF0, 16'hFFFF);     // upper bound past 0xFFFF, no wrap
        send_op(OP_CLAIM, 16'hFFFF, 16'h0000);
        send_op(OP_CHECK, 16'hFFF0, 16'hFFFF);
        send_op(OP_CLAIM, 16'h1230, 16'h0004);     // busy range
        send_op(OP_FREE, 16'h1234, 16'h0000);      // three back-to-back copies
        send_op(OP_CHECK, 16'h1234, 16'h0000);
        send_op(OP_FREE, 16'h7777, 16'hFFFF);      // absent ID
        send_op(3'd5, 16'hAAAA, 16'h5555);
        send_op(3'd6, 16'h5555, 16'hAAAA);
        send_op(3'd7, 16'hFFFF, 16'hFFFF);
        send_op(OP_CHECK, 16'h0001, 16'h0003);
        send_op(OP_FLUSH, 16'h0000, 16'h0000);
        send_op(OP_RESERVE, 16'hFFFF, 16'h0000);
        send_op(OP_FREE, 16'hFFFF, 16'h0000);
        send_op(OP_CLAIM, 16'h0000, 16'hFFFF);
        send_op(OP_CHECK, 16'h8000, 16'h7FFF);
        send_op(OP_FLUSH, 16'hFFFF, 16'hFFFF);
        drain();

        // Random episodes
        start = ops_issued;
        while (ops_issued - start < RANDOM_OPS) begin
            if (!hold_done && ops_issued - start >= 150) begin
                hold_rx   = 1'b1;
                hold_done = 1'b1;
            end
            if (fills < 2 && ops_issued - start >= 300 + fills * 450) begin
                fill_episode();
                fills++;
            end else begin
                base = pick_base();
                if (tracker.occupancy > 48)
                    send_op(OP_FLUSH, ID_W'($urandom), ID_W'($urandom));
                repeat ($urandom_range(20, 60)) pool_op(base);
            end
            if ($urandom_range(0, 3) == 0)
                drain();
        end
        drain();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (tracker.mismatches == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

>>> reserved_id_table.f
+incdir+rtl
rtl/rit_pkg.sv
rtl/rit_seq.sv
rtl/rit_dp.sv
rtl/reserved_id_table.sv
verif/rit_tb_pkg.sv
verif/testbench.sv
